@@ hdl/kaa_pkg.sv @@
// ----------------------------------------------------------------------------
// kaa_pkg
// Shared types and constants of the k-means assign and accumulate unit.
// ----------------------------------------------------------------------------
package kaa_pkg;

	// default sizes
	localparam int DEF_MAX_CLUSTERS = 16;
	localparam int DEF_MAX_DIM      = 1024;
	localparam int DEF_VALUE_BITS   = 16;

	// fixed field widths
	localparam int CMD_W     = 2;
	localparam int CLUSTER_W = 4;
	localparam int ELEMENT_W = 10;
	localparam int NC_CFG_W  = 5;
	localparam int LEN_CFG_W = 11;
	localparam int CFG_W     = 11;
	localparam int DIST_W    = 44;
	localparam int SUM_W     = 40;
	localparam int CNT_W     = 20;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	// square saturates once the magnitude needs more than this many bits
	localparam int SQ_MAG_W = 22;

	// register indexes
	localparam logic REG_CLUSTERS = 1'b0;
	localparam logic REG_VEC_LEN  = 1'b1;

	// result kinds
	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} kaa_op_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic cen_wr;
		logic smp_wr;
		logic dist_rd;
		logic sel_step;
		logic sel_first;
		logic sum_rd;
		logic sum_acc;
		logic clr_wr;
		logic dist_clr;
		logic cnt_clr;
		logic cnt_inc;
		logic out_load;
	} kaa_cmd_t;

	// datapath to controller
	typedef struct packed {
		kaa_op_t op;
		logic    load_ok;
		logic    el_in_len;
		logic    el_last;
		logic    out_busy;
	} kaa_status_t;

endpackage

@@ hdl/kaa_in_if.sv @@
// ----------------------------------------------------------------------------
// kaa_in_if
// Input channel: one command word per handshake.
// ----------------------------------------------------------------------------
interface kaa_in_if #(
	parameter int VALUE_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   cmd;
	logic [3:0]                   cluster;
	logic [9:0]                   element;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, cmd, cluster, element, value, input ready);
	modport sink   (input valid, cmd, cluster, element, value, output ready);
endinterface

@@ hdl/kaa_out_if.sv @@
// ----------------------------------------------------------------------------
// kaa_out_if
// Result channel: one assignment or read word per handshake.
// ----------------------------------------------------------------------------
interface kaa_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [3:0]         cluster_res;
	logic signed [39:0] sum;
	logic [19:0]        count;
	logic [43:0]        best_distance;

	modport source (output valid, kind, cluster_res, sum, count, best_distance, input ready);
	modport sink   (input valid, kind, cluster_res, sum, count, best_distance, output ready);
endinterface

@@ hdl/kaa_ctrl.sv @@
// ----------------------------------------------------------------------------
// kaa_ctrl
// Sequencer: decodes each word and steps the datapath through the cluster
// and element loops, the clearing sweep and the result hand-off.
// ----------------------------------------------------------------------------
module kaa_ctrl import kaa_pkg::*; #(
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_DIM      = DEF_MAX_DIM,
	localparam int CL_W  = $clog2(MAX_CLUSTERS),
	localparam int EL_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
	localparam int AW    = CL_W + EL_W,
	localparam int NC_W  = $clog2(MAX_CLUSTERS + 1),
	localparam int LEN_W = $clog2(MAX_DIM + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [NC_W-1:0]  nc,
	input  logic [LEN_W-1:0] len,
	input  logic             in_valid,
	output logic             in_ready,
	input  kaa_status_t      status,
	output kaa_cmd_t         cmd,
	output logic [AW-1:0]    idx
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_RD, S_DIST, S_DRAIN1, S_DRAIN2,
		S_SELECT, S_SUM, S_SUM_DRAIN, S_COUNT, S_OUT
	} state_t;

	state_t        state_q;
	logic [AW-1:0] idx_q;
	logic          k_last;
	logic          e_last;
	logic          a_last;

	assign k_last   = (idx_q == AW'(nc - 1'b1));
	assign e_last   = (idx_q == AW'(len - 1'b1));
	assign a_last   = (idx_q == {AW{1'b1}});
	assign idx      = idx_q;
	assign in_ready = (state_q == S_IDLE);

	// decode commands from state
	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.clr_wr    = (state_q == S_CLEAR);
		cmd.sum_rd    = (state_q == S_RD);
		cmd.dist_rd   = (state_q == S_DIST);
		cmd.sel_step  = (state_q == S_SELECT);
		cmd.sel_first = (state_q == S_SELECT) && (idx_q == '0);
		cmd.sum_acc   = (state_q == S_SUM);
		cmd.cnt_inc   = (state_q == S_COUNT);
		cmd.out_load  = (state_q == S_OUT) && !status.out_busy;
		if (state_q == S_COUNT) begin
			cmd.dist_clr = 1'b1;
		end
		if (state_q == S_DECODE) begin
			cmd.cen_wr   = (status.op == OP_LOAD) && status.load_ok;
			cmd.smp_wr   = (status.op == OP_SAMPLE) && status.el_in_len;
			cmd.dist_clr = (status.op == OP_CLEAR);
			cmd.cnt_clr  = (status.op == OP_CLEAR);
		end
	end

	// hold state and loop index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (a_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					idx_q <= '0;
					unique case (status.op)
						OP_LOAD:   state_q <= S_IDLE;
						OP_CLEAR:  state_q <= S_CLEAR;
						OP_READ:   state_q <= S_RD;
						OP_SAMPLE: state_q <= status.el_in_len ? S_DIST : S_IDLE;
						default:   state_q <= S_IDLE;
					endcase
				end
				S_RD: state_q <= S_OUT;
				S_DIST: begin
					idx_q <= idx_q + 1'b1;
					if (k_last) state_q <= S_DRAIN1;
				end
				S_DRAIN1: state_q <= S_DRAIN2;
				S_DRAIN2: begin
					idx_q   <= '0;
					state_q <= status.el_last ? S_SELECT : S_IDLE;
				end
				S_SELECT: begin
					if (k_last) begin
						idx_q   <= '0;
						state_q <= S_SUM;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SUM: begin
					idx_q <= idx_q + 1'b1;
					if (e_last) state_q <= S_SUM_DRAIN;
				end
				S_SUM_DRAIN: state_q <= S_COUNT;
				S_COUNT: state_q <= S_OUT;
				S_OUT: begin
					if (!status.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/kaa_datapath.sv @@
// ----------------------------------------------------------------------------
// kaa_datapath
// Center, sample and sum memories, distance and count accumulators, the
// squaring unit, nearest-cluster search and the result register.
// ----------------------------------------------------------------------------
module kaa_datapath import kaa_pkg::*; #(
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_DIM      = DEF_MAX_DIM,
	parameter int VALUE_BITS   = DEF_VALUE_BITS,
	localparam int CL_W  = $clog2(MAX_CLUSTERS),
	localparam int EL_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
	localparam int AW    = CL_W + EL_W,
	localparam int LEN_W = $clog2(MAX_DIM + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kaa_cmd_t                     cmd,
	input  logic [AW-1:0]                idx,
	input  logic [LEN_W-1:0]             len,
	input  logic [CMD_W-1:0]             in_cmd,
	input  logic [CLUSTER_W-1:0]         in_cluster,
	input  logic [ELEMENT_W-1:0]         in_element,
	input  logic signed [VALUE_BITS-1:0] in_value,
	output kaa_status_t                  status,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_kind,
	output logic [CLUSTER_W-1:0]         out_cluster,
	output logic signed [SUM_W-1:0]      out_sum,
	output logic [CNT_W-1:0]             out_count,
	output logic [DIST_W-1:0]            out_best
);

	localparam int DEPTH = 2 ** AW;
	localparam int VB    = VALUE_BITS;

	// memories
	logic signed [VB-1:0]    center_mem [DEPTH];
	logic signed [VB-1:0]    smp_mem    [2 ** EL_W];
	logic signed [SUM_W-1:0] sum_mem    [DEPTH];

	// flop stores
	logic [DIST_W-1:0] dist_q [MAX_CLUSTERS];
	logic [CNT_W-1:0]  cnt_q  [MAX_CLUSTERS];

	// captured word
	kaa_op_t                   op_q;
	logic [CLUSTER_W-1:0]      cl_q;
	logic [ELEMENT_W-1:0]      el_q;
	logic signed [VB-1:0]      val_q;

	logic [CL_W-1:0] cl_idx;
	logic [EL_W-1:0] el_idx;
	logic            cl_ok;
	logic            el_ok;

	// distance pipeline
	logic signed [VB-1:0] cen_rd_s1;
	logic                 dist_v_s1;
	logic [CL_W-1:0]      k_s1;
	logic [DIST_W-1:0]    sq_s2;
	logic                 dist_v_s2;
	logic [CL_W-1:0]      k_s2;
	logic signed [VB:0]   diff;
	logic [VB:0]          mag;
	logic [63:0]          mag64;
	logic [SQ_MAG_W-1:0]  m22;
	logic [DIST_W-1:0]    prod;
	logic [DIST_W-1:0]    sq;
	logic [CL_W-1:0]      dist_addr;
	logic [DIST_W-1:0]    dist_rd;
	logic [DIST_W:0]      dist_sum;

	// search
	logic [CL_W-1:0]   best_q;
	logic [DIST_W-1:0] bd_q;

	// sum update
	logic signed [SUM_W-1:0] sum_rd_q;
	logic signed [VB-1:0]    smp_rd_q;
	logic                    acc_v_s1;
	logic [EL_W-1:0]         e_s1;
	logic signed [SUM_W:0]   sum_ext;
	logic signed [SUM_W-1:0] sum_new;
	logic [AW-1:0]           sum_raddr;

	// counts and result
	logic [CL_W-1:0]  cnt_addr;
	logic [CNT_W-1:0] cnt_rd;
	logic             out_valid_q;

	assign cl_idx = CL_W'(cl_q);
	assign el_idx = EL_W'(el_q);
	assign cl_ok  = (32'(cl_q) < MAX_CLUSTERS);
	assign el_ok  = cl_ok && (32'(el_q) < 32'(len));

	assign status.op        = op_q;
	assign status.load_ok   = cl_ok && (32'(el_q) < MAX_DIM);
	assign status.el_in_len = (32'(el_q) < 32'(len));
	assign status.el_last   = (32'(el_q) == 32'(len) - 1);
	assign status.out_busy  = out_valid_q;

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= kaa_op_t'(in_cmd);
			cl_q  <= in_cluster;
			el_q  <= in_element;
			val_q <= in_value;
		end
	end

	// center and sample memories
	always_ff @(posedge clk) begin
		if (cmd.cen_wr) center_mem[{cl_idx, el_idx}] <= val_q;
		if (cmd.dist_rd) cen_rd_s1 <= center_mem[{CL_W'(idx), el_idx}];
	end

	always_ff @(posedge clk) begin
		if (cmd.smp_wr) smp_mem[el_idx] <= val_q;
		if (cmd.sum_acc) smp_rd_q <= smp_mem[EL_W'(idx)];
	end

	// square of the element difference, saturated
	always_comb begin
		diff  = (VB+1)'(cen_rd_s1) - (VB+1)'(val_q);
		mag   = diff[VB] ? (VB+1)'(-diff) : diff;
		mag64 = 64'(mag);
		m22   = mag64[SQ_MAG_W-1:0];
		prod  = DIST_W'(m22) * DIST_W'(m22);
		sq    = ((mag64 >> SQ_MAG_W) != '0) ? DIST_MAX : prod;
	end

	assign dist_addr = dist_v_s2 ? k_s2 : CL_W'(idx);
	assign dist_rd   = dist_q[dist_addr];
	assign dist_sum  = (DIST_W+1)'(dist_rd) + (DIST_W+1)'(sq_s2);

	// advance the distance pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_v_s1 <= 1'b0;
			dist_v_s2 <= 1'b0;
		end else begin
			dist_v_s1 <= cmd.dist_rd;
			dist_v_s2 <= dist_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		k_s1  <= CL_W'(idx);
		k_s2  <= k_s1;
		sq_s2 <= sq;
	end

	// distance accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) dist_q[i] <= '0;
		end else if (cmd.dist_clr) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) dist_q[i] <= '0;
		end else if (dist_v_s2) begin
			dist_q[k_s2] <= dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
		end
	end

	// nearest cluster, lowest index wins ties
	always_ff @(posedge clk) begin
		if (cmd.sel_step && (cmd.sel_first || (dist_rd < bd_q))) begin
			bd_q   <= dist_rd;
			best_q <= CL_W'(idx);
		end
	end

	// sum memory: one read port, one write port
	assign sum_raddr = cmd.sum_acc ? {best_q, EL_W'(idx)} : {cl_idx, el_idx};
	assign sum_ext   = (SUM_W+1)'(sum_rd_q) + (SUM_W+1)'(smp_rd_q);

	always_comb begin
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_new = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_new = sum_ext[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_rd || cmd.sum_acc) sum_rd_q <= sum_mem[sum_raddr];
		if (cmd.clr_wr) begin
			sum_mem[idx] <= '0;
		end else if (acc_v_s1) begin
			sum_mem[{best_q, e_s1}] <= sum_new;
		end
		e_s1 <= EL_W'(idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_v_s1 <= 1'b0;
		else         acc_v_s1 <= cmd.sum_acc;
	end

	// counts
	assign cnt_addr = (op_q == OP_READ) ? cl_idx : best_q;
	assign cnt_rd   = cnt_q[cnt_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) cnt_q[i] <= '0;
		end else if (cmd.cnt_clr) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) cnt_q[i] <= '0;
		end else if (cmd.cnt_inc && (cnt_q[best_q] != CNT_MAX)) begin
			cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (op_q == OP_READ) begin
				out_kind    <= KIND_READ;
				out_cluster <= cl_q;
				out_sum     <= el_ok ? sum_rd_q : '0;
				out_count   <= cl_ok ? cnt_rd : '0;
				out_best    <= '0;
			end else begin
				out_kind    <= KIND_ASSIGN;
				out_cluster <= CLUSTER_W'(best_q);
				out_sum     <= '0;
				out_count   <= cnt_rd;
				out_best    <= bd_q;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hdl/kmeans_assign_accumulate_unit.sv @@
// Sequence: a load writes the center memory; a read fetches the sum, then loads the
//   result; a sample element accumulates each active cluster's distance, and a last
//   element then picks the nearest cluster, updates its sums and count and loads a result.
// Throughput: one word at a time; the center memory read port, one cluster per
//   cycle, sets the sample element rate. A result waiting in the output holds the next.
// Reset: clears control state and sweeps all 2^(CL_W+EL_W) sum memory entries
//   (16384 by default); a clear command repeats that sweep.
// ----------------------------------------------------------------------------
// kmeans_assign_accumulate_unit
// One k-means assignment pass: distance accumulation, nearest-cluster choice
// and per-cluster sum and count accumulation.
// ----------------------------------------------------------------------------
module kmeans_assign_accumulate_unit import kaa_pkg::*; #(
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_DIM      = DEF_MAX_DIM,
	parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	kaa_in_if.sink           in_ch,
	kaa_out_if.source        out_ch,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CL_W  = $clog2(MAX_CLUSTERS);
	localparam int EL_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW    = CL_W + EL_W;
	localparam int NC_W  = $clog2(MAX_CLUSTERS + 1);
	localparam int LEN_W = $clog2(MAX_DIM + 1);

	logic [NC_CFG_W-1:0]  nc_q;
	logic [LEN_CFG_W-1:0] len_q;
	logic [NC_W-1:0]      nc;
	logic [LEN_W-1:0]     len;
	kaa_cmd_t             cmd;
	kaa_status_t          status;
	logic [AW-1:0]        idx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q  <= NC_CFG_W'(16);
			len_q <= LEN_CFG_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLUSTERS: nc_q  <= cfg_data[NC_CFG_W-1:0];
				REG_VEC_LEN:  len_q <= cfg_data[LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp into the supported range
	always_comb begin
		if (nc_q == '0)                      nc = NC_W'(1);
		else if (32'(nc_q) > MAX_CLUSTERS)   nc = NC_W'(MAX_CLUSTERS);
		else                                 nc = NC_W'(nc_q);
		if (len_q == '0)                     len = LEN_W'(1);
		else if (32'(len_q) > MAX_DIM)       len = LEN_W'(MAX_DIM);
		else                                 len = LEN_W'(len_q);
	end

	kaa_ctrl #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_DIM      (MAX_DIM)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.nc       (nc),
		.len      (len),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd),
		.idx      (idx)
	);

	kaa_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_DIM      (MAX_DIM),
		.VALUE_BITS   (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.idx         (idx),
		.len         (len),
		.in_cmd      (in_ch.cmd),
		.in_cluster  (in_ch.cluster),
		.in_element  (in_ch.element),
		.in_value    (in_ch.value),
		.status      (status),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_kind    (out_ch.kind),
		.out_cluster (out_ch.cluster_res),
		.out_sum     (out_ch.sum),
		.out_count   (out_ch.count),
		.out_best    (out_ch.best_distance)
	);

	// one word in flight at a time
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("word accepted while previous word still in work");

	// an assignment always counts its own sample
	a_assign_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.kind == KIND_ASSIGN)) |-> (out_ch.count != '0))
		else $error("assignment with zero count");

	// a read carries no distance
	a_read_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.kind == KIND_READ)) |-> (out_ch.best_distance == '0))
		else $error("read word carries a distance");

	// a new result is loaded only into a free result register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !status.out_busy)
		else $error("result register overwritten");

endmodule
